@@ src/lsp_pkg.sv @@
// ----------------------------------------------------------------------------
// lsp_pkg: shared types and constants for the line-of-sight path cost block
// Grid geometry, field widths, command codes, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lsp_pkg;

  // Grid geometry. The grid is row-major, with a power-of-two width.
  localparam int COLS_LOG2  = 6;
  localparam int ROWS_LOG2  = 6;
  localparam int IDX_W      = COLS_LOG2 + ROWS_LOG2;
  localparam int GRID_CELLS = 1 << IDX_W;
  localparam int AXIS_W     = (COLS_LOG2 > ROWS_LOG2) ? COLS_LOG2 : ROWS_LOG2;
  // The decision value stays within plus or minus twice the major span.
  localparam int D_W        = AXIS_W + 3;

  // Field widths on the ports.
  localparam int CELL_FIELD_W = 12;
  localparam int COST_W       = 8;
  localparam int SUM_W        = 16;
  localparam int IN_DATA_W    = 2 * CELL_FIELD_W + COST_W;
  localparam int OUT_DATA_W   = SUM_W;

  localparam logic [COST_W-1:0] BLOCKED_COST = 8'd255;

  // Command codes carried on in_tuser.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_DONE
  } lsp_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic write_cell;
    logic load_query;
    logic setup;
    logic walk;
    logic load_out;
  } lsp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic walk_done;
    logic out_free;
  } lsp_sts_t;

  // Drops index bits above the grid size.
  function automatic logic [IDX_W-1:0] grid_index(
    input logic [CELL_FIELD_W-1:0] cell_field
  );
    grid_index = IDX_W'(cell_field);
  endfunction

endpackage

@@ src/lsp_ctrl.sv @@
// ----------------------------------------------------------------------------
// lsp_ctrl: command sequencer for the line-of-sight path cost block
// Accepts write and query beats, steps a query through setup and the walk,
// and hands the result to the output register once it is free.
// ----------------------------------------------------------------------------
module lsp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_cmd,
  output logic              in_tready,
  input  lsp_pkg::lsp_sts_t sts,
  output lsp_pkg::lsp_cmd_t cmd
);

  lsp_pkg::lsp_state_t state_r, state_nxt;
  logic                accept;

  assign accept = in_tvalid && in_tready;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lsp_pkg::ST_IDLE: begin
        if (accept && in_cmd == lsp_pkg::CMD_QUERY) begin
          state_nxt = lsp_pkg::ST_SETUP;
        end
      end
      lsp_pkg::ST_SETUP: begin
        state_nxt = lsp_pkg::ST_WALK;
      end
      lsp_pkg::ST_WALK: begin
        if (sts.walk_done) begin
          state_nxt = lsp_pkg::ST_DONE;
        end
      end
      lsp_pkg::ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = lsp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lsp_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      lsp_pkg::ST_IDLE: begin
        in_tready      = 1'b1;
        cmd.write_cell = accept && in_cmd == lsp_pkg::CMD_WRITE;
        cmd.load_query = accept && in_cmd == lsp_pkg::CMD_QUERY;
      end
      lsp_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
      end
      lsp_pkg::ST_WALK: begin
        cmd.walk = 1'b1;
      end
      lsp_pkg::ST_DONE: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

@@ src/lsp_datapath.sv @@
// ----------------------------------------------------------------------------
// lsp_datapath: cost grid, line stepper and accumulator
// Holds the cost grid memory, orders the endpoints of a query, steps the
// line one cell per cycle and sums the costs read back, with an output
// register toward the result channel.
// ----------------------------------------------------------------------------
module lsp_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [lsp_pkg::CELL_FIELD_W-1:0]    first_cell,
  input  logic [lsp_pkg::CELL_FIELD_W-1:0]    second_cell,
  input  logic [lsp_pkg::COST_W-1:0]          cell_cost,
  input  lsp_pkg::lsp_cmd_t                   cmd,
  output lsp_pkg::lsp_sts_t                   sts,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lsp_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tuser
);

  localparam int CL = lsp_pkg::COLS_LOG2;
  localparam int RL = lsp_pkg::ROWS_LOG2;
  localparam int AW = lsp_pkg::AXIS_W;
  localparam int DW = lsp_pkg::D_W;

  // Cost grid memory.
  logic [lsp_pkg::COST_W-1:0] grid_mem [lsp_pkg::GRID_CELLS];
  logic [lsp_pkg::COST_W-1:0] rd_data_r;
  logic [lsp_pkg::IDX_W-1:0]  rd_addr;

  // Latched query endpoints.
  logic [lsp_pkg::IDX_W-1:0] first_idx_r, second_idx_r;

  // Setup logic.
  logic [CL-1:0]        x0, x1, adx;
  logic [RL-1:0]        y0, y1, ady;
  logic [AW-1:0]        adx_e, ady_e;
  logic                 col_major, swap, step_neg;
  logic [AW-1:0]        a0, a1, b0, b1, da, db;
  logic signed [DW-1:0] d0, inc_hi, inc_lo;

  // Walk state.
  logic [AW-1:0]        a_r, a_end_r, b_r;
  logic signed [DW-1:0] d_r, inc_hi_r, inc_lo_r;
  logic                 step_neg_r, col_major_r, issue_on_r;
  logic                 rd_valid_r, rd_last_r;
  logic                 issue, blocked, walk_done;
  logic [lsp_pkg::SUM_W-1:0] acc_r;
  logic                 ok_r;

  // Output register.
  logic                      out_valid_r;
  logic [lsp_pkg::SUM_W-1:0] out_sum_r;
  logic                      out_ok_r;

  // Grid write port.
  always_ff @(posedge clk) begin
    if (cmd.write_cell) begin
      grid_mem[lsp_pkg::grid_index(first_cell)] <= cell_cost;
    end
  end

  // Grid read port, registered.
  always_ff @(posedge clk) begin
    rd_data_r <= grid_mem[rd_addr];
  end

  // Query latch.
  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      first_idx_r  <= lsp_pkg::grid_index(first_cell);
      second_idx_r <= lsp_pkg::grid_index(second_cell);
    end
  end

  // Major axis choice and endpoint ordering.
  always_comb begin
    x0    = first_idx_r[CL-1:0];
    y0    = first_idx_r[lsp_pkg::IDX_W-1:CL];
    x1    = second_idx_r[CL-1:0];
    y1    = second_idx_r[lsp_pkg::IDX_W-1:CL];
    adx   = (x1 > x0) ? x1 - x0 : x0 - x1;
    ady   = (y1 > y0) ? y1 - y0 : y0 - y1;
    adx_e = AW'(adx);
    ady_e = AW'(ady);
    col_major = ady_e < adx_e;
    if (col_major) begin
      swap = x0 > x1;
      a0   = AW'(swap ? x1 : x0);
      a1   = AW'(swap ? x0 : x1);
      b0   = AW'(swap ? y1 : y0);
      b1   = AW'(swap ? y0 : y1);
      da   = adx_e;
      db   = ady_e;
    end else begin
      swap = y0 > y1;
      a0   = AW'(swap ? y1 : y0);
      a1   = AW'(swap ? y0 : y1);
      b0   = AW'(swap ? x1 : x0);
      b1   = AW'(swap ? x0 : x1);
      da   = ady_e;
      db   = adx_e;
    end
    step_neg = b1 < b0;
    d0       = $signed(DW'({db, 1'b0})) - $signed(DW'(da));
    inc_hi   = $signed(DW'({db, 1'b0})) - $signed(DW'({da, 1'b0}));
    inc_lo   = $signed(DW'({db, 1'b0}));
  end

  // Cell address of the current walk position.
  assign rd_addr = col_major_r ? {b_r[RL-1:0], a_r[CL-1:0]} : {a_r[RL-1:0], b_r[CL-1:0]};

  // A walk ends on a blocked cell or after the far endpoint is summed.
  assign blocked   = rd_valid_r && rd_data_r == lsp_pkg::BLOCKED_COST;
  assign walk_done = rd_valid_r && (blocked || rd_last_r);
  assign issue     = cmd.walk && issue_on_r && !walk_done;

  // Line stepper.
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      a_r         <= a0;
      a_end_r     <= a1;
      b_r         <= b0;
      d_r         <= d0;
      inc_hi_r    <= inc_hi;
      inc_lo_r    <= inc_lo;
      step_neg_r  <= step_neg;
      col_major_r <= col_major;
    end else if (issue) begin
      a_r <= a_r + AW'(1);
      if (d_r > 0) begin
        b_r <= step_neg_r ? b_r - AW'(1) : b_r + AW'(1);
        d_r <= d_r + inc_hi_r;
      end else begin
        d_r <= d_r + inc_lo_r;
      end
    end
  end

  // Read tracking control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_on_r <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= issue;
      if (cmd.setup) begin
        issue_on_r <= 1'b1;
      end else if (walk_done || (issue && a_r == a_end_r)) begin
        issue_on_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_last_r <= a_r == a_end_r;
  end

  // Cost accumulator.
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      acc_r <= '0;
      ok_r  <= 1'b1;
    end else if (rd_valid_r) begin
      if (blocked) begin
        ok_r <= 1'b0;
      end else begin
        acc_r <= acc_r + lsp_pkg::SUM_W'(rd_data_r);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_sum_r <= acc_r;
      out_ok_r  <= ok_r;
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_sum_r;
  assign out_tuser     = out_ok_r;
  assign sts.walk_done = walk_done;
  assign sts.out_free  = !out_valid_r || out_tready;

`ifndef SYNTHESIS
  // A result is loaded only when the previous one has left.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result loaded over a waiting result");

  // A cell read only comes back from a read issued during the walk.
  a_read_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid_r |-> $past(cmd.walk))
    else $error("cell read outside a walk");

  // The walk ends only while the controller is walking.
  a_done_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    walk_done |-> cmd.walk)
    else $error("walk end outside a walk");

  // No read is issued once the walk has ended.
  a_no_issue_after: assert property (@(posedge clk) disable iff (!rst_n)
    walk_done |=> !rd_valid_r)
    else $error("read issued after the walk ended");
`endif

endmodule

@@ src/line_of_sight_path_cost.sv @@
// ----------------------------------------------------------------------------
// line_of_sight_path_cost: straight-line path cost over a grid of cell costs
// Top level: stream ports, controller and datapath.
// ----------------------------------------------------------------------------
// A write beat (in_tuser 0) stores one 8-bit cell cost and gives no
// result. A query beat (in_tuser 1) walks the line between two cells,
// both ends included, and returns one result: path_cost, the sum of the
// costs walked modulo 65536, and reachable, which is 0 when a cell of cost
// 255 lies on the line (the sum then stops before that cell). From
// acceptance a query passes through a setup state, a walk state that
// issues one cell read per cell on the line through the single read port
// of the cost grid memory and waits for the last read to come back, and a
// done state that loads the result into the output register. The next
// beat is taken only once the controller is back in idle after the load,
// so a new query is not taken before the last one is through. A blocked
// cell ends the walk early. While a result waits on out_tready, the next
// finished query is held in the done state and no new beat is taken.
// Cells read by a query must have been written since reset.
module line_of_sight_path_cost (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [11:0] first_cell, [23:12] second_cell, [31:24] cell_cost
  input  logic [lsp_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] command
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [15:0] path_cost
  output logic [lsp_pkg::OUT_DATA_W-1:0]   out_tdata,
  // [0] reachable
  output logic                             out_tuser
);

  localparam int CW = lsp_pkg::CELL_FIELD_W;

  lsp_pkg::lsp_cmd_t cmd;
  lsp_pkg::lsp_sts_t sts;

  lsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lsp_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .first_cell  (in_tdata[CW-1:0]),
    .second_cell (in_tdata[2*CW-1:CW]),
    .cell_cost   (in_tdata[lsp_pkg::IN_DATA_W-1:2*CW]),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

@@ dv/line_of_sight_path_cost_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_of_sight_path_cost_test: self-checking bench for the path cost block
// Writes cell costs and issues line queries over the stream ports. A local
// line tracer and cost map predict each result not given by hand in the
// directed table, and each is compared field by field with the result beats.
// ----------------------------------------------------------------------------
module line_of_sight_path_cost_test;

  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_ITEMS  = 800;
  localparam int HOLD_CYCLES   = 600;
  localparam int DRAIN_CYCLES  = 80;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DIRECTED_ROWS = 25;
  localparam int GRID_COLS     = 1 << lsp_pkg::COLS_LOG2;
  localparam int GRID_ROWS     = 1 << lsp_pkg::ROWS_LOG2;

  typedef logic [lsp_pkg::CELL_FIELD_W-1:0] cell_idx_t;
  typedef logic [lsp_pkg::COST_W-1:0]       cost_t;
  typedef logic [lsp_pkg::IDX_W-1:0]        grid_idx_t;

  // One query result: reachable travels on tuser, path_cost on tdata.
  typedef struct packed {
    logic                      reachable;
    logic [lsp_pkg::SUM_W-1:0] path_cost;
  } path_result_t;

  // One directed beat, with a hand-computed result where it is obvious.
  typedef struct packed {
    logic         cmd;
    cell_idx_t    first_cell;
    cell_idx_t    second_cell;
    cost_t        cell_cost;
    logic         typed;
    path_result_t result;
  } stim_row_t;

  // Cells 0, 1, 2, 64 and 65 form a small patch near the origin; 63, 4032,
  // 4094 and 4095 sit in the corners and along the last row.
  localparam stim_row_t DIRECTED_STIM [DIRECTED_ROWS] = '{
    '{lsp_pkg::CMD_WRITE, 12'd0,    12'd0,    8'd10,  1'b0, '{1'b0, 16'd0}},
    '{lsp_pkg::CMD_WRITE, 12'd1,    12'd0,    8'd255, 1'b0, '{1'b0, 16'd0}},
    '{lsp_pkg::CMD_WRITE, 12'd2,    12'd0,    8'd254, 1'b0, '{1'b0, 16'd0}},
    '{lsp_pkg::CMD_WRITE, 12'd64,   12'd0,    8'd0,   1'b0, '{1'b0, 16'd0}},
    '{lsp_pkg::CMD_WRITE, 12'd65,   12'd0,    8'd7,   1'b0, '{1'b0, 16'd0}},
    // Equal endpoints walk a single cell.
    '{lsp_pkg::CMD_QUERY, 12'd0,    12'd0,    8'd0,   1'b1, '{1'b1, 16'd10}},
    // Blocked first cell gives a zero sum.
    '{lsp_pkg::CMD_QUERY, 12'd1,    12'd1,    8'd0,   1'b1, '{1'b0, 16'd0}},
    '{lsp_pkg::CMD_QUERY, 12'd2,    12'd2,    8'd255, 1'b1, '{1'b1, 16'd254}},
    // Diagonal tie walks along rows, in both directions.
    '{lsp_pkg::CMD_QUERY, 12'd0,    12'd65,   8'd0,   1'b1, '{1'b1, 16'd17}},
    '{lsp_pkg::CMD_QUERY, 12'd65,   12'd0,    8'd0,   1'b1, '{1'b1, 16'd17}},
    // Column-major walk stops before the blocked cell, either way round, then a row-major walk.
    '{lsp_pkg::CMD_QUERY, 12'd0,    12'd2,    8'd0,   1'b1, '{1'b0, 16'd10}},
    '{lsp_pkg::CMD_QUERY, 12'd2,    12'd0,    8'd0,   1'b1, '{1'b0, 16'd10}},
    '{lsp_pkg::CMD_QUERY, 12'd0,    12'd64,   8'd0,   1'b1, '{1'b1, 16'd10}},
    // Shallow lines whose minor coordinate steps downward.
    '{lsp_pkg::CMD_QUERY, 12'd64,   12'd2,    8'd0,   1'b0, '{1'b0, 16'd0}},
    '{lsp_pkg::CMD_QUERY, 12'd2,    12'd64,   8'd0,   1'b0, '{1'b0, 16'd0}},
    '{lsp_pkg::CMD_WRITE, 12'd4095, 12'd4095, 8'd255, 1'b0, '{1'b0, 16'd0}},
    '{lsp_pkg::CMD_WRITE, 12'd4032, 12'd4095, 8'd1,   1'b0, '{1'b0, 16'd0}},
    '{lsp_pkg::CMD_WRITE, 12'd63,   12'd0,    8'd128, 1'b0, '{1'b0, 16'd0}},
    '{lsp_pkg::CMD_QUERY, 12'd4095, 12'd4095, 8'd255, 1'b1, '{1'b0, 16'd0}},
    '{lsp_pkg::CMD_QUERY, 12'd4032, 12'd4032, 8'd0,   1'b1, '{1'b1, 16'd1}},
    '{lsp_pkg::CMD_QUERY, 12'd63,   12'd63,   8'd0,   1'b1, '{1'b1, 16'd128}},
    '{lsp_pkg::CMD_WRITE, 12'd4094, 12'd0,    8'd200, 1'b0, '{1'b0, 16'd0}},
    '{lsp_pkg::CMD_QUERY, 12'd4094, 12'd4095, 8'd0,   1'b1, '{1'b0, 16'd200}},
    '{lsp_pkg::CMD_QUERY, 12'd4095, 12'd4094, 8'd0,   1'b1, '{1'b0, 16'd200}},
    // Row ordering puts the blocked cell first.
    '{lsp_pkg::CMD_QUERY, 12'd1,    12'd64,   8'd0,   1'b1, '{1'b0, 16'd0}}
  };

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [lsp_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                           in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [lsp_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tuser;

  // Local copy of the grid and of which cells have been written.
  cost_t                 cost_map [lsp_pkg::GRID_CELLS];
  bit                    cell_written [lsp_pkg::GRID_CELLS];
  grid_idx_t             line_cells [$];
  path_result_t          path_results [$];

  int                    src_idle_pct;
  int                    snk_idle_pct;
  bit                    hold_req;
  int                    items_sent;
  int                    error_count;
  int                    cycle_count;

  line_of_sight_path_cost uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fills line_cells with the cells on the line, in walking order. The
  // major axis is the row axis unless the column span is strictly larger,
  // and the walk always increases along the major axis.
  function automatic void trace_line(input cell_idx_t from_cell, input cell_idx_t to_cell);
    int c0, r0, c1, r1, maj0, min0, maj1, min1;
    int span, rise, step, dec, minor, m;
    bit col_major;
    c0 = int'(from_cell) % GRID_COLS;
    r0 = (int'(from_cell) >> lsp_pkg::COLS_LOG2) % GRID_ROWS;
    c1 = int'(to_cell) % GRID_COLS;
    r1 = (int'(to_cell) >> lsp_pkg::COLS_LOG2) % GRID_ROWS;
    col_major = ((r1 > r0) ? r1 - r0 : r0 - r1) < ((c1 > c0) ? c1 - c0 : c0 - c1);
    if (col_major) begin
      maj0 = c0; min0 = r0; maj1 = c1; min1 = r1;
    end else begin
      maj0 = r0; min0 = c0; maj1 = r1; min1 = c1;
    end
    if (maj0 > maj1) begin
      m = maj0; maj0 = maj1; maj1 = m;
      m = min0; min0 = min1; min1 = m;
    end
    span = maj1 - maj0;
    rise = min1 - min0;
    step = 1;
    if (rise < 0) begin
      step = -1;
      rise = -rise;
    end
    dec = 2 * rise - span;
    minor = min0;
    line_cells.delete();
    for (m = maj0; m <= maj1; m++) begin
      if (col_major)
        line_cells.insert(line_cells.size(), grid_idx_t'((minor << lsp_pkg::COLS_LOG2) | m));
      else
        line_cells.insert(line_cells.size(), grid_idx_t'((m << lsp_pkg::COLS_LOG2) | minor));
      if (dec > 0) begin
        minor += step;
        dec += 2 * (rise - span);
      end else begin
        dec += 2 * rise;
      end
    end
  endfunction

  // Sums the costs along the line, stopping before the first blocked cell.
  function automatic path_result_t predict_path_cost(input cell_idx_t from_cell,
                                                     input cell_idx_t to_cell);
    path_result_t res;
    int k;
    trace_line(from_cell, to_cell);
    res.reachable = 1'b1;
    res.path_cost = '0;
    for (k = 0; k < line_cells.size(); k++) begin
      if (cost_map[line_cells[k]] == lsp_pkg::BLOCKED_COST) begin
        res.reachable = 1'b0;
        break;
      end
      res.path_cost += lsp_pkg::SUM_W'(cost_map[line_cells[k]]);
    end
    return res;
  endfunction

  // Costs lean toward the blocked value and the extremes.
  function automatic cost_t draw_cost();
    case ($urandom_range(0, 19))
      0:       return lsp_pkg::BLOCKED_COST;
      1:       return '0;
      2:       return lsp_pkg::BLOCKED_COST - 8'd1;
      default: return cost_t'($urandom_range(0, 255));
    endcase
  endfunction

  // A cell within seven columns and rows of the origin, kept on the grid.
  function automatic cell_idx_t nearby_cell(input cell_idx_t origin);
    int col, row;
    col = int'(origin) % GRID_COLS + int'($urandom_range(0, 14)) - 7;
    row = (int'(origin) >> lsp_pkg::COLS_LOG2) % GRID_ROWS + int'($urandom_range(0, 14)) - 7;
    if (col < 0) col = 0;
    if (col >= GRID_COLS) col = GRID_COLS - 1;
    if (row < 0) row = 0;
    if (row >= GRID_ROWS) row = GRID_ROWS - 1;
    return cell_idx_t'((row << lsp_pkg::COLS_LOG2) | col);
  endfunction

  // Offers one beat after random idle cycles and waits until it is taken.
  // On acceptance the write is applied to the local map, or the query's
  // result is queued.
  task automatic send_beat(input logic cmd, input cell_idx_t first_cell,
                           input cell_idx_t second_cell, input cost_t cell_cost,
                           input bit typed, input path_result_t typed_result);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {cell_cost, second_cell, first_cell};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (cmd == lsp_pkg::CMD_WRITE) begin
      cost_map[first_cell[lsp_pkg::IDX_W-1:0]] = cell_cost;
      cell_written[first_cell[lsp_pkg::IDX_W-1:0]] = 1'b1;
    end else begin
      path_results.insert(path_results.size(),
                          typed ? typed_result : predict_path_cost(first_cell, second_cell));
    end
  endtask

  // Writes every cell on the line not yet written, then queries the line.
  // Most lines are short; one in ten spans the grid at random.
  task automatic issue_query();
    cell_idx_t start_cell, end_cell;
    grid_idx_t missing [$];
    int k;
    start_cell = cell_idx_t'($urandom());
    if ($urandom_range(0, 9) == 0)
      end_cell = cell_idx_t'($urandom());
    else
      end_cell = nearby_cell(start_cell);
    trace_line(start_cell, end_cell);
    for (k = 0; k < line_cells.size(); k++)
      if (!cell_written[line_cells[k]]) missing.insert(missing.size(), line_cells[k]);
    for (k = 0; k < missing.size(); k++)
      send_beat(lsp_pkg::CMD_WRITE, cell_idx_t'(missing[k]), cell_idx_t'($urandom()),
                draw_cost(), 1'b0, '0);
    send_beat(lsp_pkg::CMD_QUERY, start_cell, end_cell, cost_t'($urandom()), 1'b0, '0);
  endtask

  // Mostly complete queries, with stray writes that overwrite the grid.
  task automatic random_phase(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 20)
        send_beat(lsp_pkg::CMD_WRITE, cell_idx_t'($urandom()), cell_idx_t'($urandom()),
                  draw_cost(), 1'b0, '0);
      else
        issue_query();
    end
  endtask

  // Stimulus: reset, directed table, then three random phases with
  // different idle patterns, then drain and report.
  initial begin
    int r;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= lsp_pkg::CMD_WRITE;
    src_idle_pct = 8;
    snk_idle_pct = 55;
    hold_req     = 1'b0;
    items_sent   = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < DIRECTED_ROWS; r++)
      send_beat(DIRECTED_STIM[r].cmd, DIRECTED_STIM[r].first_cell, DIRECTED_STIM[r].second_cell,
                DIRECTED_STIM[r].cell_cost, DIRECTED_STIM[r].typed, DIRECTED_STIM[r].result);

    random_phase(RANDOM_ITEMS / 3);
    src_idle_pct = 55;
    snk_idle_pct = 8;
    random_phase(RANDOM_ITEMS / 3);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_req     = 1'b1;
    random_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    in_tvalid <= 1'b0;

    while (path_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Result side ready: random stalls, plus one long hold-off on request
  // so that the block backs up into its input.
  initial begin
    int held;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  // Compare each result beat with the oldest queued expectation.
  path_result_t oldest_result;
  initial error_count = 0;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (path_results.size() == 0) begin
        $error("result beat with nothing expected: reachable %0d path_cost %0d",
               out_tuser, out_tdata);
        error_count++;
      end else begin
        oldest_result = path_results[0];
        path_results.delete(0);
        if (out_tuser !== oldest_result.reachable) begin
          $error("reachable: expected %0d, actual %0d", oldest_result.reachable, out_tuser);
          error_count++;
        end
        if (out_tdata !== oldest_result.path_cost) begin
          $error("path_cost: expected %0d, actual %0d", oldest_result.path_cost, out_tdata);
          error_count++;
        end
      end
    end
  end

  // Timeout.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ line_of_sight_path_cost.f @@
src/lsp_pkg.sv
src/lsp_ctrl.sv
src/lsp_datapath.sv
src/line_of_sight_path_cost.sv
dv/line_of_sight_path_cost_test.sv
